FILE: rtl/salc_pkg.sv
package salc_pkg;

	localparam int ADDR_W  = 64;
	localparam int COUNT_W = 32;
	localparam int CFG_W   = 6;
	localparam int CIDX_W  = 2;

	localparam logic [CIDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_WAYS       = 2'd2;

	localparam logic [1:0] OP_IFETCH = 2'd0;
	localparam logic [1:0] OP_MODIFY = 2'd3;

	typedef struct packed {
		logic cap;    // capture the input beat, clear per-item flags
		logic rd;     // issue set read
		logic cmp;    // compare ways, build the updated row
		logic wr;     // write row back, bump totals
		logic first;  // current access is the first of the item
	} cmd_t;

endpackage

FILE: rtl/set_assoc_lru_cache_sim_core.sv
// channel   signals                                  beat taken when
// input     in_valid, in_stall, op, address          in_valid && !in_stall
// result    out_valid, out_stall, hits_now .. counts out_valid && !out_stall
// config    cfg_we, cfg_index, cfg_data              cfg_we
//
// One item at a time. Fetch goes straight to the result, with no access to the
// set memory. Load/store does one read / compare / write-back pass, modify two.
// Reset clears totals and per-set row-written flags at once and resets config;
// unwritten sets read as empty. Input stalls until the result beat is taken.
module set_assoc_lru_cache_sim_core #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int STAMP_WIDTH  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [salc_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   op,
	input  logic [salc_pkg::ADDR_W-1:0]  address,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   hits_now,
	output logic                         missed,
	output logic                         evicted,
	output logic [salc_pkg::COUNT_W-1:0] hit_count,
	output logic [salc_pkg::COUNT_W-1:0] miss_count,
	output logic [salc_pkg::COUNT_W-1:0] eviction_count
);

	salc_pkg::cmd_t cmd;

	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	salc_datapath #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.STAMP_WIDTH  (STAMP_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.address        (address),
		.cmd            (cmd),
		.hits_now       (hits_now),
		.missed         (missed),
		.evicted        (evicted),
		.hit_count      (hit_count),
		.miss_count     (miss_count),
		.eviction_count (eviction_count)
	);

endmodule

FILE: rtl/salc_ctrl.sv
module salc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        op,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output salc_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic       second_q;   // a second access is still owed (modify)
	logic       first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			second_q <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						first_q  <= 1'b1;
						second_q <= (op == salc_pkg::OP_MODIFY);
						state_q  <= (op == salc_pkg::OP_IFETCH) ? S_OUT : S_RD;
					end
				end
				S_RD:  state_q <= S_CMP;
				S_CMP: state_q <= S_WR;
				S_WR: begin
					first_q <= 1'b0;
					if (second_q) begin
						second_q <= 1'b0;
						state_q  <= S_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd       = '0;
		cmd.cap   = (state_q == S_IDLE) && in_valid;
		cmd.rd    = (state_q == S_RD);
		cmd.cmp   = (state_q == S_CMP);
		cmd.wr    = (state_q == S_WR);
		cmd.first = first_q;
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.cap, cmd.rd, cmd.cmp, cmd.wr}))
		else $error("more than one datapath command");
	a_wr_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> (state_q == S_RD || state_q == S_OUT))
		else $error("write-back not followed by read or result");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !second_q)
		else $error("pending second access while idle");
	a_out_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

endmodule

FILE: rtl/salc_datapath.sv
module salc_datapath #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int STAMP_WIDTH  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [salc_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [salc_pkg::CFG_W-1:0]         cfg_data,
	input  logic [salc_pkg::ADDR_W-1:0]        address,
	input  salc_pkg::cmd_t                     cmd,
	output logic [1:0]                         hits_now,
	output logic                               missed,
	output logic                               evicted,
	output logic [salc_pkg::COUNT_W-1:0]       hit_count,
	output logic [salc_pkg::COUNT_W-1:0]       miss_count,
	output logic [salc_pkg::COUNT_W-1:0]       eviction_count
);

	localparam int SETS   = 1 << MAX_SET_BITS;
	localparam int WAYW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int AW     = salc_pkg::ADDR_W;
	localparam int CW     = salc_pkg::COUNT_W;

	logic [2:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd4;
			block_bits_q <= 6'd4;
			ways_q       <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				salc_pkg::REG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				salc_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data;
				salc_pkg::REG_WAYS:       ways_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// address split
	logic [2:0]              sb;
	logic [6:0]              sbb;
	logic [MAX_SET_BITS-1:0] set_d;
	logic [AW-1:0]           tag_d;
	logic [AW-1:0]           shifted;

	always_comb begin
		sb      = (int'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
		sbb     = 7'(sb) + 7'(block_bits_q);
		shifted = address >> block_bits_q;
		set_d   = shifted[MAX_SET_BITS-1:0] & ~({MAX_SET_BITS{1'b1}} << sb);
		tag_d   = sbb[6] ? '0 : (address >> sbb[5:0]);
	end

	logic [MAX_SET_BITS-1:0] set_q;
	logic [AW-1:0]           tag_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			set_q <= set_d;
			tag_q <= tag_d;
		end
	end

	// set rows; a row never written reads as all-zero
	logic [MAX_WAYS-1:0][AW-1:0]          tag_mem   [SETS];
	logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp_mem [SETS];
	logic [MAX_WAYS-1:0]                  valid_mem [SETS];
	logic [SETS-1:0]                      row_ok_q;

	logic [MAX_WAYS-1:0][AW-1:0]          rtag_s1;
	logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] rstamp_s1;
	logic [MAX_WAYS-1:0]                  rvalid_s1;
	logic                                 rok_s1;

	logic [MAX_WAYS-1:0][AW-1:0]          wtag_q;
	logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] wstamp_q;
	logic [MAX_WAYS-1:0]                  wvalid_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rtag_s1   <= tag_mem[set_q];
			rstamp_s1 <= stamp_mem[set_q];
			rvalid_s1 <= valid_mem[set_q];
		end
		if (cmd.wr) begin
			tag_mem[set_q]   <= wtag_q;
			stamp_mem[set_q] <= wstamp_q;
			valid_mem[set_q] <= wvalid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rok_s1   <= 1'b0;
		end else begin
			if (cmd.rd)
				rok_s1 <= row_ok_q[set_q];
			if (cmd.wr)
				row_ok_q[set_q] <= 1'b1;
		end
	end

	// way compare, stamp max and min
	logic [MAX_WAYS-1:0][AW-1:0]          ctag;
	logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] cstamp;
	logic [MAX_WAYS-1:0]                  cvalid;
	logic [MAX_WAYS-1:0][AW-1:0]          ntag;
	logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] nstamp_row;
	logic [MAX_WAYS-1:0]                  nvalid;
	logic [STAMP_WIDTH-1:0]               top, low, nstamp;
	logic                                 hit_f, free_f;
	logic [WAYW-1:0]                      hit_w, free_w, ev_w, sel_w;
	int                                   ways_eff;

	always_comb begin
		ctag     = rok_s1 ? rtag_s1   : '0;
		cstamp   = rok_s1 ? rstamp_s1 : '0;
		cvalid   = rok_s1 ? rvalid_s1 : '0;
		ways_eff = (ways_q == 4'd0) ? 1 :
		           ((int'(ways_q) > MAX_WAYS) ? MAX_WAYS : int'(ways_q));
		top      = '0;
		hit_f    = 1'b0;
		free_f   = 1'b0;
		hit_w    = '0;
		free_w   = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < ways_eff) begin
				if (cstamp[w] > top)
					top = cstamp[w];
				if (cvalid[w]) begin
					if (!hit_f && ctag[w] == tag_q) begin
						hit_f = 1'b1;
						hit_w = WAYW'(w);
					end
				end else if (!free_f) begin
					free_f = 1'b1;
					free_w = WAYW'(w);
				end
			end
		end
		low  = cstamp[0];
		ev_w = '0;
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (w < ways_eff && cstamp[w] < low) begin
				low  = cstamp[w];
				ev_w = WAYW'(w);
			end
		end
		nstamp = (&top) ? top : top + 1'b1;
		sel_w  = hit_f ? hit_w : (free_f ? free_w : ev_w);
		// updated row: selected way gets the new stamp, a miss also fills it
		ntag              = ctag;
		nstamp_row        = cstamp;
		nvalid            = cvalid;
		nstamp_row[sel_w] = nstamp;
		if (!hit_f) begin
			ntag[sel_w]   = tag_q;
			nvalid[sel_w] = 1'b1;
		end
	end

	logic hit_q, ev_q;

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			wtag_q   <= ntag;
			wstamp_q <= nstamp_row;
			wvalid_q <= nvalid;
			hit_q    <= hit_f;
			ev_q     <= !hit_f && !free_f;
		end
	end

	// result and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_now       <= '0;
			missed         <= 1'b0;
			evicted        <= 1'b0;
			hit_count      <= '0;
			miss_count     <= '0;
			eviction_count <= '0;
		end else if (cmd.cap) begin
			hits_now <= '0;
			missed   <= 1'b0;
			evicted  <= 1'b0;
		end else if (cmd.wr) begin
			if (hit_q) begin
				hits_now <= hits_now + 2'd1;
				if (hit_count != {CW{1'b1}})
					hit_count <= hit_count + 1'b1;
			end else begin
				if (cmd.first)
					missed <= 1'b1;
				if (miss_count != {CW{1'b1}})
					miss_count <= miss_count + 1'b1;
				if (ev_q) begin
					if (cmd.first)
						evicted <= 1'b1;
					if (eviction_count != {CW{1'b1}})
						eviction_count <= eviction_count + 1'b1;
				end
			end
		end
	end

endmodule
